FILE: rtl/wmf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wmf_pkg: shared types and constants of the window mode filter
// Request layout between front and back, state encoding, intensity weights.
// ---------------------------------------------------------------------------
package wmf_pkg;

    localparam int LANES    = 4;
    localparam int BINS     = 256;
    localparam int BIN_BITS = 8;

    localparam logic [15:0] W_RED   = 16'd77;
    localparam logic [15:0] W_GREEN = 16'd150;
    localparam logic [15:0] W_BLUE  = 16'd29;

    localparam logic [2:0] INTENSITY_MIN_CHANS = 3'd3;

    typedef enum logic {
        CFG_MODE      = 1'b0,
        CFG_CHAN_CNT  = 1'b1
    } t_cfg_idx;

    // classified request as the back end consumes it
    typedef struct packed {
        logic [LANES-1:0][BIN_BITS-1:0] bin;      // histogram address per bank
        logic [LANES-1:0][7:0]          px;       // channel bytes, unused ones zeroed
        logic [LANES-1:0]               bank_en;  // banks that count this pixel
        logic [LANES-1:0]               chan_en;  // channels returned
        logic                           intensity;
        logic                           last;
    } t_item;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE,
        S_EMIT
    } t_back_state;

    typedef struct packed {
        logic clearing;
        logic emitting;
    } t_back_stat;

endpackage

FILE: rtl/wmf_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wmf_in_if / wmf_out_if: pixel and result channels
// Valid/ready handshake with the channel payload.
// ---------------------------------------------------------------------------
interface wmf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] chan_0;
    logic [7:0] chan_1;
    logic [7:0] chan_2;
    logic [7:0] chan_3;
    logic       window_end;

    modport source (output valid, chan_0, chan_1, chan_2, chan_3, window_end, input ready);
    modport sink   (input valid, chan_0, chan_1, chan_2, chan_3, window_end, output ready);
endinterface

interface wmf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_0;
    logic [7:0] out_1;
    logic [7:0] out_2;
    logic [7:0] out_3;

    modport source (output valid, out_0, out_1, out_2, out_3, input ready);
    modport sink   (input valid, out_0, out_1, out_2, out_3, output ready);
endinterface

FILE: rtl/window_mode_filter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// window_mode_filter: histogram mode filter over one pixel window
// Per-channel or intensity histograms, one result per window.
// ---------------------------------------------------------------------------
//  channel  dir  payload                          request
//  s_in     in   chan_0..chan_3, window_end       one window pixel
//  m_out    out  out_0..out_3                     one filtered pixel
//  cfg      in   i_cfg_we, i_cfg_index, i_cfg_data  register write
//
// Per pixel the back end does a bin RAM read, then increment and write.
// The last pixel of a window adds an emit state to load the result and a
// sweep that zeroes all 256 bins of each bin RAM; the same sweep runs
// after reset. A result still waiting in the output register holds the back
// end in emit. The two-entry queue takes up to two pixels while the back end
// is busy; after that the input stalls.
// ---------------------------------------------------------------------------
module window_mode_filter import wmf_pkg::*; #(
    parameter int COUNT_BITS   = 12,
    parameter int MAX_CHANNELS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_index,
    input  logic [2:0] i_cfg_data,
    wmf_in_if.sink     s_in,
    wmf_out_if.source  m_out
);
    t_item      push_item;
    t_item      head_item;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;
    t_back_stat stat;

    wmf_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_in        (s_in),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_item      (push_item)
    );

    wmf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    wmf_back #(.COUNT_BITS(COUNT_BITS), .MAX_CHANNELS(MAX_CHANNELS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (head_item),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_stat  (stat),
        .m_out   (m_out)
    );

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("request taken from empty queue");

    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.clearing |-> !pop)
        else $error("request taken during clearing sweep");

    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_out.valid) |-> $past(stat.emitting))
        else $error("result raised outside emit");
endmodule

FILE: rtl/wmf_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wmf_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module wmf_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/wmf_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wmf_front: pixel intake and classification
// Holds the settings, works out bins, bank and channel masks per pixel.
// ---------------------------------------------------------------------------
module wmf_front import wmf_pkg::*; #(
    parameter int MAX_CHANNELS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_index,
    input  logic [2:0] i_cfg_data,
    wmf_in_if.sink     s_in,
    input  logic       i_q_full,
    output logic       o_push,
    output t_item      o_item
);
    localparam logic [2:0] MAX_N = 3'(MAX_CHANNELS);

    logic       r_mode;
    logic [2:0] r_chan_cnt;
    logic [2:0] n_used;
    logic [15:0] sum;
    logic [LANES-1:0][7:0] px;
    logic [LANES-1:0] chan_en;
    logic intensity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_chan_cnt <= 3'd3;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MODE:     r_mode     <= i_cfg_data[0];
                CFG_CHAN_CNT: r_chan_cnt <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    always_comb begin
        n_used = (r_chan_cnt == 3'd0) ? 3'd1 : r_chan_cnt;
        if (n_used > MAX_N) begin
            n_used = MAX_N;
        end
        intensity = r_mode && (n_used >= INTENSITY_MIN_CHANS);
        px[0] = s_in.chan_0;
        px[1] = s_in.chan_1;
        px[2] = s_in.chan_2;
        px[3] = s_in.chan_3;
        for (int b = 0; b < LANES; b++) begin
            chan_en[b] = (3'(b) < n_used);
        end
        sum = W_RED * 16'(px[0]) + W_GREEN * 16'(px[1]) + W_BLUE * 16'(px[2]);

        for (int b = 0; b < LANES; b++) begin
            o_item.px[b]  = chan_en[b] ? px[b] : 8'd0;
            o_item.bin[b] = px[b];
        end
        if (intensity) begin
            o_item.bin[0] = sum[15:8];
        end
        o_item.bank_en   = intensity ? 4'b0001 : chan_en;
        o_item.chan_en   = chan_en;
        o_item.intensity = intensity;
        o_item.last      = s_in.window_end;
    end

    assign s_in.ready = !i_q_full;
    assign o_push     = s_in.valid && !i_q_full;
endmodule

FILE: rtl/wmf_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wmf_fifo: two-entry request queue
// Decouples classification from the histogram update.
// ---------------------------------------------------------------------------
module wmf_fifo import wmf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_full,
    output logic  o_empty
);
    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
endmodule

FILE: rtl/wmf_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wmf_back: histogram update, best tracking and result register
// Read-modify-write of the bin RAMs, window emit and clearing sweep.
// ---------------------------------------------------------------------------
module wmf_back import wmf_pkg::*; #(
    parameter int COUNT_BITS   = 12,
    parameter int MAX_CHANNELS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_item      i_item,
    input  logic       i_empty,
    output logic       o_pop,
    output t_back_stat o_stat,
    wmf_out_if.source  m_out
);
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    t_back_state r_state, n_state;
    t_item       r_item;
    logic [BIN_BITS-1:0] r_clr_addr;
    logic [LANES-1:0][COUNT_BITS-1:0] r_best_cnt;
    logic [LANES-1:0][7:0]            r_best_val;
    logic [LANES-1:0][7:0]            r_out;
    logic                             r_out_valid;
    logic [LANES-1:0][COUNT_BITS-1:0] rdata;
    logic [LANES-1:0][COUNT_BITS-1:0] inc;
    logic load_out;
    logic clearing;

    for (genvar b = 0; b < LANES; b++) begin : g_bank
        if (b < MAX_CHANNELS) begin : g_ram
            wmf_ram #(.WIDTH(COUNT_BITS), .DEPTH(BINS)) u_ram (
                .i_clk   (i_clk),
                .i_we    (clearing || (r_state == S_UPDATE && r_item.bank_en[b])),
                .i_waddr (clearing ? r_clr_addr : r_item.bin[b]),
                .i_wdata (clearing ? '0 : inc[b]),
                .i_re    (o_pop),
                .i_raddr (i_item.bin[b]),
                .o_rdata (rdata[b])
            );
        end else begin : g_none
            assign rdata[b] = '0;
        end
        assign inc[b] = (rdata[b] == CMAX) ? rdata[b] : rdata[b] + 1'b1;
    end

    assign clearing = (r_state == S_CLEAR);
    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign load_out = (r_state == S_EMIT) && (!r_out_valid || m_out.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr_addr == BIN_BITS'(BINS - 1)) n_state = S_IDLE;
            S_IDLE:   if (!i_empty) n_state = S_UPDATE;
            S_UPDATE: n_state = r_item.last ? S_EMIT : S_IDLE;
            S_EMIT:   if (load_out) n_state = S_CLEAR;
            default:  n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_best_cnt  <= '0;
            r_best_val  <= '0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (load_out) begin
                r_best_cnt <= '0;
                r_best_val <= '0;
            end else if (r_state == S_UPDATE) begin
                for (int b = 0; b < LANES; b++) begin
                    if (r_item.bank_en[b] && inc[b] > r_best_cnt[b]) begin
                        r_best_cnt[b] <= inc[b];
                        if (!r_item.intensity) begin
                            r_best_val[b] <= r_item.px[b];
                        end
                    end
                end
                // intensity winner takes every channel of its pixel
                if (r_item.intensity && inc[0] > r_best_cnt[0]) begin
                    r_best_val <= r_item.px;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        if (load_out) begin
            for (int b = 0; b < LANES; b++) begin
                r_out[b] <= r_item.chan_en[b] ? r_best_val[b] : 8'd0;
            end
        end
    end

    assign m_out.valid = r_out_valid;
    assign m_out.out_0 = r_out[0];
    assign m_out.out_1 = r_out[1];
    assign m_out.out_2 = r_out[2];
    assign m_out.out_3 = r_out[3];

    assign o_stat.clearing = clearing;
    assign o_stat.emitting = (r_state == S_EMIT);
endmodule
